// ----- src/psr_pkg.sv -----
`timescale 1ns / 1ps
package psr_pkg;

    localparam int SEG_PAYLOAD_DEF = 25;
    localparam int FRAME_W         = 6;
    localparam int LEN_W           = 10;
    localparam int CRC_W           = 16;

    localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_XOROUT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY_REFL = 16'h8408;
    localparam logic [CRC_W-1:0]   CRC_RESIDUE   = 16'h0F47;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT   = 6'd32;
    localparam logic [LEN_W-1:0]   LEN_MAX       = 10'd1023;

    localparam logic MODE_START = 1'b1;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_CRC_GOOD = 2'd1,
        STAT_CRC_ERR  = 2'd2,
        STAT_SEQ_ERR  = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_READ,
        CS_FOLD,
        CS_STATUS
    } ctl_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic [4:0] byte_position;
    } in_beat_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        payload_byte;
        stat_t             status;
        logic [CRC_W-1:0]  checksum;
        logic [LEN_W-1:0]  packet_length;
        logic              last;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic store_wr;
        logic seg_start;
        logic rd;
        logic load_byte;
        logic load_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pos_data;
        logic pos_ctrl;
        logic start;
        logic seg_go;
        logic n_zero;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

    // reflected CRC-16, one byte folded in
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/psr_ctrl.sv -----
`timescale 1ns / 1ps
module psr_ctrl
    import psr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_valid && !stat.start && stat.pos_ctrl) begin
                    state_next = (stat.seg_go && !stat.n_zero) ? CS_READ : CS_STATUS;
                end
            end
            CS_READ: begin
                state_next = CS_FOLD;
            end
            CS_FOLD: begin
                if (stat.out_free) begin
                    state_next = stat.idx_last ? CS_STATUS : CS_READ;
                end
            end
            CS_STATUS: begin
                if (stat.out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            CS_IDLE: begin
                s_ready       = 1'b1;
                cmd.clear     = s_valid && stat.start;
                cmd.store_wr  = s_valid && !stat.start && stat.pos_data;
                cmd.seg_start = s_valid && !stat.start && stat.pos_ctrl;
            end
            CS_READ: begin
                cmd.rd = 1'b1;
            end
            CS_FOLD: begin
                cmd.load_byte = stat.out_free;
            end
            CS_STATUS: begin
                cmd.load_status = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/psr_dp.sv -----
`timescale 1ns / 1ps
module psr_dp
    import psr_pkg::*;
#(
    parameter int SEGMENT_PAYLOAD = SEG_PAYLOAD_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int CNT_W = $clog2(SEGMENT_PAYLOAD + 1);
    localparam int IDX_W = (SEGMENT_PAYLOAD > 1) ? $clog2(SEGMENT_PAYLOAD) : 1;
    localparam logic [5:0] PAY6 = 6'(SEGMENT_PAYLOAD);

    logic [7:0] store [SEGMENT_PAYLOAD];

    logic [FRAME_W-1:0] frame_reg;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   n_reg, idx_reg;
    logic               last_reg, seq_reg;
    logic [7:0]         rd_data_reg;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic [5:0] pos6, field6, n_dec;
    logic       is_last, match;
    logic [CRC_W-1:0] final_sum;

    // control byte decode, next CRC, length and final checksum
    always_comb begin
        pos6      = {1'b0, s_data.byte_position};
        field6    = {1'b0, s_data.data_byte[6:2]};
        is_last   = s_data.data_byte[7];
        match     = field6 == frame_reg;
        n_dec     = is_last ? ((field6 < PAY6) ? field6 : PAY6) : PAY6;
        crc_next  = crc_fold(crc_reg, rd_data_reg);
        len_next  = (len_reg != LEN_MAX) ? len_reg + 1'b1 : len_reg;
        final_sum = crc_reg ^ CRC_XOROUT;
    end

    always_comb begin
        stat.pos_data = pos6 < PAY6;
        stat.pos_ctrl = pos6 == PAY6;
        stat.start    = s_data.mode == MODE_START;
        stat.seg_go   = is_last || match;
        stat.n_zero   = n_dec == 6'd0;
        stat.idx_last = idx_reg == CNT_W'(n_reg - 1'b1);
        stat.out_free = !m_valid_reg || m_ready;
    end

    // segment buffer, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            store[s_data.byte_position[IDX_W-1:0]] <= s_data.data_byte;
        end
        if (cmd.rd) begin
            rd_data_reg <= store[idx_reg[IDX_W-1:0]];
        end
    end

    // segment walk
    always_ff @(posedge aclk) begin
        if (cmd.seg_start) begin
            n_reg    <= CNT_W'(n_dec);
            idx_reg  <= '0;
            last_reg <= is_last;
            seq_reg  <= !is_last && !match;
        end else if (cmd.load_byte) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // packet state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            frame_reg <= '0;
            crc_reg   <= CRC_INIT;
            len_reg   <= '0;
        end else if (cmd.load_byte) begin
            crc_reg <= crc_next;
            len_reg <= len_next;
        end else if (cmd.load_status && !last_reg && !seq_reg && frame_reg < FRAME_LIMIT) begin
            frame_reg <= frame_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_byte || cmd.load_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            m_data_reg.kind          <= KIND_BYTE;
            m_data_reg.payload_byte  <= rd_data_reg;
            m_data_reg.status        <= STAT_ACCEPTED;
            m_data_reg.checksum      <= crc_next;
            m_data_reg.packet_length <= len_next;
            m_data_reg.last          <= 1'b0;
        end else if (cmd.load_status) begin
            m_data_reg.kind          <= KIND_STATUS;
            m_data_reg.payload_byte  <= '0;
            m_data_reg.packet_length <= len_reg;
            m_data_reg.last          <= 1'b1;
            if (last_reg) begin
                m_data_reg.checksum <= final_sum;
                m_data_reg.status   <= (final_sum == CRC_RESIDUE) ? STAT_CRC_GOOD
                                                                  : STAT_CRC_ERR;
            end else begin
                m_data_reg.checksum <= crc_reg;
                m_data_reg.status   <= seq_reg ? STAT_SEQ_ERR : STAT_ACCEPTED;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/packet_segment_reassembler_crc.sv -----
`timescale 1ns / 1ps
// Channel   Ports                        Beat
// input     s_valid s_ready s_data       mode, data_byte, byte_position
// result    m_valid m_ready m_data       kind, payload_byte, status, checksum,
//                                        packet_length, last
//
// Start and data beats are taken in the idle state and yield nothing.
// A control beat accepting n bytes holds the input off while it yields n+1 result
// beats: a buffer read and a CRC fold per byte, then the status beat.
// A sequence error or an empty last segment therefore goes straight to the status beat.
// aresetn is synchronous; the segment buffer is not cleared by reset.
// m_ready low stalls the walk in the fold and status states; idle input is taken even with a beat waiting.
module packet_segment_reassembler_crc
    import psr_pkg::*;
#(
    parameter int SEGMENT_PAYLOAD = SEG_PAYLOAD_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: idle / buffer read / fold and emit / status beat
    psr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // segment buffer, CRC, counters and output register
    psr_dp #(
        .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a control beat always starts a walk or a status beat: busy next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode != MODE_START &&
         {1'b0, s_data.byte_position} == 6'(SEGMENT_PAYLOAD)) |=> !s_ready)
        else $error("control beat did not start segment handling");

    // a start beat yields nothing and leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_START) |=> s_ready)
        else $error("start beat left the controller busy");

    // crc good only with the residue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_STATUS && m_data.status == STAT_CRC_GOOD)
        |-> (m_data.checksum == CRC_RESIDUE && m_data.last))
        else $error("crc good reported without residue");

endmodule
